// ===== rtl/lzf_pkg.sv =====
// LZF block decompressor package: widths, phase codes and the
// controller/datapath command and status structs. No dependencies.
package lzf_pkg;
   localparam int HISTORY_DEPTH = 8192;
   localparam int HIST_AW = $clog2(HISTORY_DEPTH);
   localparam logic [20:0] LIMIT_MAX = 21'd1048576;
   localparam logic [20:0] LIMIT_RESET = 21'd262144;

   typedef enum logic [1:0] {
      PH_CTRL = 2'd0,
      PH_LIT = 2'd1,
      PH_EXT = 2'd2,
      PH_LOW = 2'd3
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_COPY = 4'b0010,
      ST_EMIT = 4'b0100,
      ST_WAIT = 4'b1000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       take;     // latch the accepted item into the parser
      logic       put;      // append one byte to the group / history
      logic       put_copy; // byte comes from history, else the literal
      logic       emit;     // move the group into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       copy_start; // accepted item opens a copy
      logic       lit_put;    // accepted item is one literal
      logic       copy_more;  // copy bytes remain after the next put
      logic       copy_pend;  // copy bytes remain to be put
      logic       grp_full;   // group holds eight bytes after the next put
      logic       need_rsp;   // item produces at least one result
      logic       out_busy;   // output register holds a result that is not taken
   } sts_type;
endpackage

// ===== rtl/lzf_if.sv =====
// Valid/ready channel interfaces for the LZF decompressor.
// Depends on nothing.
interface lzf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       block_end;
   modport source (output valid, in_byte, block_end, input ready);
   modport sink (input valid, in_byte, block_end, output ready);
endinterface

interface lzf_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  lane_0, lane_1, lane_2, lane_3, lane_4, lane_5, lane_6, lane_7;
   logic [3:0]  byte_count;
   logic        run_last;
   logic        error_flag;
   logic [20:0] total_length;
   modport source (output valid, lane_0, lane_1, lane_2, lane_3, lane_4, lane_5,
                   lane_6, lane_7, byte_count, run_last, error_flag, total_length,
                   input ready);
   modport sink (input valid, lane_0, lane_1, lane_2, lane_3, lane_4, lane_5,
                 lane_6, lane_7, byte_count, run_last, error_flag, total_length,
                 output ready);
endinterface

interface lzf_csr_if;
   logic        valid;
   logic        ready;
   logic [20:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== rtl/lzf_ctrl.sv =====
// LZF controller: sequences accept, copy and group emission.
// Depends on lzf_pkg.
module lzf_ctrl import lzf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE) && !sts.out_busy;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.take = 1'b1;
               if (sts.copy_start) begin
                  state_in = ST_COPY;
               end else begin
                  cmd.put = sts.lit_put;
                  if (sts.need_rsp) begin
                     cmd.emit = 1'b1;
                  end
               end
            end
         end
         ST_COPY: begin
            cmd.put = 1'b1;
            cmd.put_copy = 1'b1;
            if (!sts.copy_more || sts.grp_full) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // wait for the output register, then hand over the group
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               state_in = sts.copy_pend ? ST_COPY : ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> state_ff == ST_IDLE) else $error("take outside idle");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !sts.out_busy) else $error("emit over busy output");
endmodule

// ===== rtl/lzf_datapath.sv =====
// LZF datapath: parser registers, history ring, group and output register.
// Depends on lzf_pkg and the channel interfaces.
module lzf_datapath import lzf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_in_byte,
   input  logic        req_block_end,
   input  logic [20:0] limit,
   input  cmd_type     cmd,
   output sts_type     sts,
   lzf_rsp_if.source   rsp
);
   logic [7:0] ring [HISTORY_DEPTH];
   logic [20:0] out_count_ff, out_count_in;
   phase_type   phase_ff, phase_in;
   logic [5:0]  lit_left_ff, lit_left_in;
   logic [8:0]  mlen_ff, mlen_in;
   logic [4:0]  dhigh_ff, dhigh_in;
   logic        err_ff, err_in;
   logic [9:0]  copy_left_ff;       // bytes still to copy
   logic [13:0] dist_ff;
   logic        end_ff;             // block end of the last accepted item
   logic [7:0]  grp_ff [8];
   logic [3:0]  grp_n_ff;
   logic [7:0]  rd_ff;              // registered ring read
   logic [HIST_AW-1:0] rd_addr, wr_addr;
   logic        rsp_valid_ff;
   logic [7:0]  lane_ff [8];
   logic [3:0]  cnt_ff;
   logic        last_ff, eflag_ff;
   logic [20:0] tot_ff;

   logic [20:0] eff_limit;
   logic [21:0] lit_sum, ref_sum;
   logic [13:0] dist_new, dist_use;
   logic        lit_ok, ref_ok, open_copy, end_now, lit_byte;
   logic [7:0]  put_byte;
   logic [3:0]  grp_n_next;

   assign eff_limit = (limit > LIMIT_MAX) ? LIMIT_MAX : limit;
   assign lit_sum = {1'b0, out_count_ff} + 22'(req_in_byte) + 22'd1;
   assign ref_sum = {1'b0, out_count_ff} + 22'(mlen_ff) + 22'd2;
   assign dist_new = {1'b0, dhigh_ff, req_in_byte} + 14'd1;
   assign lit_ok = lit_sum <= {1'b0, eff_limit};
   assign ref_ok = (ref_sum <= {1'b0, eff_limit}) &&
                   ({7'd0, dist_new} <= out_count_ff);
   assign open_copy = !err_ff && phase_ff == PH_LOW && ref_ok;
   assign lit_byte = !err_ff && phase_ff == PH_LIT;

   // parser update for the accepted item
   always_comb begin
      phase_in = phase_ff;
      lit_left_in = lit_left_ff;
      mlen_in = mlen_ff;
      dhigh_in = dhigh_ff;
      err_in = err_ff;
      if (!err_ff) begin
         unique case (phase_ff)
            PH_CTRL: begin
               if (req_in_byte < 8'd32) begin
                  if (!lit_ok) begin
                     err_in = 1'b1;
                  end else begin
                     lit_left_in = 6'(req_in_byte) + 6'd1;
                     phase_in = PH_LIT;
                  end
               end else begin
                  mlen_in = 9'(req_in_byte[7:5]);
                  dhigh_in = req_in_byte[4:0];
                  phase_in = (req_in_byte[7:5] == 3'd7) ? PH_EXT : PH_LOW;
               end
            end
            PH_LIT: begin
               lit_left_in = lit_left_ff - 6'd1;
               if (lit_left_ff == 6'd1) phase_in = PH_CTRL;
            end
            PH_EXT: begin
               mlen_in = mlen_ff + 9'(req_in_byte);
               phase_in = PH_LOW;
            end
            PH_LOW: begin
               phase_in = PH_CTRL;
               if (!ref_ok) err_in = 1'b1;
            end
            default: phase_in = PH_CTRL;
         endcase
      end
      if (req_block_end && phase_in != PH_CTRL) err_in = 1'b1;
   end

   assign end_now = cmd.take ? req_block_end : end_ff;
   assign put_byte = cmd.put_copy ? rd_ff : req_in_byte;
   assign grp_n_next = cmd.put ? grp_n_ff + 4'd1 : grp_n_ff;
   assign dist_use = cmd.take ? dist_new : dist_ff;
   assign wr_addr = HIST_AW'(out_count_ff);
   // fetch the source of the next copy byte: one ahead while a byte is put
   assign rd_addr = HIST_AW'(out_count_ff + (cmd.put ? 21'd1 : 21'd0) - 21'(dist_use));

   assign sts.copy_start = open_copy;
   assign sts.lit_put = lit_byte;
   assign sts.copy_more = copy_left_ff > 10'd1;
   assign sts.copy_pend = copy_left_ff != 10'd0;
   assign sts.grp_full = grp_n_ff == 4'd7;
   assign sts.need_rsp = lit_byte || req_block_end;
   assign sts.out_busy = rsp_valid_ff && !rsp.ready;

   // pass the byte being written straight through when a copy of
   // distance one reads it back
   always_ff @(posedge clock) begin
      if (cmd.put && rd_addr == wr_addr) rd_ff <= put_byte;
      else rd_ff <= ring[rd_addr];
      if (cmd.put) ring[wr_addr] <= put_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_count_ff <= '0;
         phase_ff <= PH_CTRL;
         lit_left_ff <= '0;
         mlen_ff <= '0;
         dhigh_ff <= '0;
         err_ff <= 1'b0;
         copy_left_ff <= '0;
         grp_n_ff <= '0;
         rsp_valid_ff <= 1'b0;
         end_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         if (cmd.take) begin
            phase_ff <= phase_in;
            lit_left_ff <= lit_left_in;
            mlen_ff <= mlen_in;
            dhigh_ff <= dhigh_in;
            err_ff <= err_in;
            end_ff <= req_block_end;
            if (open_copy) begin
               copy_left_ff <= 10'(mlen_ff) + 10'd2;
               dist_ff <= dist_new;
            end
         end
         if (cmd.put) begin
            out_count_ff <= out_count_ff + 21'd1;
            grp_ff[grp_n_ff[2:0]] <= put_byte;
            if (cmd.put_copy) copy_left_ff <= copy_left_ff - 10'd1;
         end
         grp_n_ff <= grp_n_next;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
            for (int i = 0; i < 8; i++) begin
               if (4'(i) < grp_n_ff) lane_ff[i] <= grp_ff[i];
               else if (4'(i) == grp_n_ff && cmd.put) lane_ff[i] <= put_byte;
               else lane_ff[i] <= 8'd0;
            end
            cnt_ff <= grp_n_next;
            grp_n_ff <= '0;
            last_ff <= cmd.take || !sts.copy_pend;
            eflag_ff <= cmd.take ? err_in : err_ff;
            tot_ff <= out_count_ff + (cmd.put ? 21'd1 : 21'd0);
            if (end_now && (cmd.take || !sts.copy_pend)) begin
               out_count_ff <= '0;
               phase_ff <= PH_CTRL;
               lit_left_ff <= '0;
               mlen_ff <= '0;
               dhigh_ff <= '0;
               err_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.lane_0 = lane_ff[0];
   assign rsp.lane_1 = lane_ff[1];
   assign rsp.lane_2 = lane_ff[2];
   assign rsp.lane_3 = lane_ff[3];
   assign rsp.lane_4 = lane_ff[4];
   assign rsp.lane_5 = lane_ff[5];
   assign rsp.lane_6 = lane_ff[6];
   assign rsp.lane_7 = lane_ff[7];
   assign rsp.byte_count = cnt_ff;
   assign rsp.run_last = last_ff;
   assign rsp.error_flag = eflag_ff;
   assign rsp.total_length = tot_ff;

   a_grp_bound: assert property (@(posedge clock) disable iff (reset)
      grp_n_ff <= 4'd8) else $error("group overrun");
   a_put_copy: assert property (@(posedge clock) disable iff (reset)
      cmd.put_copy |-> copy_left_ff != 10'd0) else $error("copy past length");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff) else $error("result dropped");
endmodule

// ===== rtl/lzf_block_decompressor.sv =====
// LZF block decompressor top level: controller plus datapath.
// Control and literal bytes are taken one per cycle while the output is not stalled; a literal's group is offered
// on rsp the cycle after its item. The low byte of a back reference holds the input while the copy runs:
// the controller passes an entry state, puts one ring byte per cycle, hands over each group of up to eight
// in an emit state and ends in a wait state; a stalled result holds it longer.
// Reset is synchronous; the history ring is not cleared.
module lzf_block_decompressor import lzf_pkg::*; (
   input logic     clock,
   input logic     reset,
   lzf_req_if.sink   req,
   lzf_rsp_if.source rsp,
   lzf_csr_if.sink   csr
);
   logic [20:0] limit_ff;
   cmd_type     cmd;
   sts_type     sts;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr.valid) begin
         limit_ff <= csr.data;
      end
   end

   lzf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .sts(sts), .cmd(cmd)
   );

   lzf_datapath u_dp (
      .clock(clock), .reset(reset), .req_in_byte(req.in_byte),
      .req_block_end(req.block_end), .limit(limit_ff), .cmd(cmd), .sts(sts),
      .rsp(rsp)
   );
endmodule

// ===== verif/tb.sv =====
// Self-checking bench for lzf_block_decompressor: directed table, then random
// LZF blocks checked against an in-bench decoder. Needs lzf_pkg and lzf_if.
module tb import lzf_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0][7:0] lanes;
      logic [3:0]      cnt;
      logic            last;
      logic            err;
      logic [20:0]     total;
   } group_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       block_end;
      logic       typed;
      group_type  want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lzf_req_if req_ch();
   lzf_rsp_if rsp_ch();
   lzf_csr_if csr_ch();

   lzf_block_decompressor dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch), .csr(csr_ch)
   );

   // decoder state
   logic [7:0]  ring [HISTORY_DEPTH];
   int unsigned dec_count;
   phase_type   dec_phase;
   int unsigned lit_left;
   int unsigned match_len;
   int unsigned dist_high;
   bit          dec_err;
   logic [20:0] out_limit;
   group_type   grp;
   group_type   fresh_q[$];
   group_type   group_q[$];

   int tx_idle;
   int rx_idle;
   int hold_ask = 0;
   int hold_done = 0;
   int hold_left;
   int mismatches;
   int items_sent;
   int gen_out;

   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 400;

   logic [20:0] limits [7] = '{21'd1, 21'd40, 21'd1048576, 21'h1fffff, 21'd0, 21'd300,
                               LIMIT_RESET};

   dir_row_type dir_tab [22] = '{
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b1, '{lanes:64'hFF, cnt:4'd1, last:1'b1, err:1'b0, total:21'd1}},
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h55, 1'b0, 1'b0, '0},
      '{8'h20, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'hE0, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hC3, 1'b0, 1'b0, '0},
      '{8'h04, 1'b0, 1'b0, '0},
      '{8'h1F, 1'b1, 1'b0, '0},
      '{8'h40, 1'b0, 1'b0, '0},
      '{8'h05, 1'b1, 1'b1, '{lanes:64'h0, cnt:4'd0, last:1'b1, err:1'b1, total:21'd0}},
      '{8'h00, 1'b1, 1'b1, '{lanes:64'h0, cnt:4'd0, last:1'b1, err:1'b1, total:21'd0}},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'hA5, 1'b0, 1'b0, '0},
      '{8'h5A, 1'b1, 1'b0, '0},
      '{8'hE0, 1'b1, 1'b1, '{lanes:64'h0, cnt:4'd0, last:1'b1, err:1'b1, total:21'd0}},
      '{8'h9F, 1'b0, 1'b1, '0},
      '{8'h7F, 1'b1, 1'b1, '{lanes:64'h0, cnt:4'd0, last:1'b1, err:1'b1, total:21'd0}}
   };

   function automatic int unsigned limit_eff();
      return (out_limit > LIMIT_MAX) ? LIMIT_MAX : out_limit;
   endfunction

   task automatic flush_grp();
      grp.err = dec_err;
      grp.total = dec_count[20:0];
      fresh_q.push_back(grp);
      grp = '0;
   endtask

   task automatic put_byte(input logic [7:0] b);
      ring[dec_count % HISTORY_DEPTH] = b;
      dec_count++;
      grp.lanes[grp.cnt] = b;
      grp.cnt++;
      if (grp.cnt == 4'd8) flush_grp();
   endtask

   // decode one compressed byte into fresh_q
   task automatic decode_byte(input logic [7:0] b, input logic blk_end);
      int unsigned len;
      int unsigned ref_dist;
      fresh_q.delete();
      grp = '0;
      if (!dec_err) begin
         case (dec_phase)
            PH_CTRL: begin
               if (b < 8'd32) begin
                  if (dec_count + b + 1 > limit_eff()) dec_err = 1'b1;
                  else begin
                     lit_left = b + 1;
                     dec_phase = PH_LIT;
                  end
               end else begin
                  match_len = b >> 5;
                  dist_high = b & 8'h1f;
                  dec_phase = (match_len == 7) ? PH_EXT : PH_LOW;
               end
            end
            PH_LIT: begin
               put_byte(b);
               lit_left = (lit_left - 1) & 6'h3f;
               if (lit_left == 0) dec_phase = PH_CTRL;
            end
            PH_EXT: begin
               match_len = (match_len + b) & 9'h1ff;
               dec_phase = PH_LOW;
            end
            default: begin
               len = match_len + 2;
               ref_dist = (dist_high << 8) + b + 1;
               dec_phase = PH_CTRL;
               if (dec_count + len > limit_eff() || ref_dist > dec_count) dec_err = 1'b1;
               else begin
                  for (int k = 0; k < len; k++)
                     put_byte(ring[(dec_count - ref_dist) % HISTORY_DEPTH]);
               end
            end
         endcase
      end
      if (grp.cnt != 0) flush_grp();
      if (blk_end) begin
         if (!dec_err && dec_phase != PH_CTRL) dec_err = 1'b1;
         if (fresh_q.size() == 0) flush_grp();
         fresh_q[$].err = dec_err;
         fresh_q[$].total = dec_count[20:0];
      end
      if (fresh_q.size() != 0) fresh_q[$].last = 1'b1;
      if (blk_end) begin
         dec_count = 0;
         dec_phase = PH_CTRL;
         lit_left = 0;
         match_len = 0;
         dist_high = 0;
         dec_err = 1'b0;
      end
   endtask

   // offer one item, hold until accepted; returns just after the accepting edge
   task automatic send_item(input logic [7:0] b, input logic blk_end);
      if ($urandom_range(0, 99) < tx_idle) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.block_end <= blk_end;
      do @(negedge clock); while (!req_ch.ready);
      decode_byte(b, blk_end);
      items_sent++;
      @(posedge clock);
   endtask

   task automatic idle_drain();
      req_ch.valid <= 1'b0;
      while (group_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [20:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= value;
      do @(negedge clock); while (!csr_ch.ready);
      out_limit = value;
      @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // one LZF block, mostly well formed, sometimes broken
   task automatic send_block();
      logic [7:0] plan_b[$];
      int         ntok;
      int         r;
      int         ln;
      int         d;
      int         ext;
      int         f;
      gen_out = 0;
      ntok = $urandom_range(1, 6);
      for (int t = 0; t < ntok; t++) begin
         r = $urandom_range(0, 99);
         if (r < 45 || gen_out == 0 && r < 92) begin
            ln = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 4);
            plan_b.push_back(8'(ln - 1));
            repeat (ln) plan_b.push_back(8'($urandom_range(0, 255)));
            gen_out += ln;
         end else if (r < 92) begin
            if ($urandom_range(0, 9) == 0) begin
               f = 7;
               ext = $urandom_range(0, 255);
               ln = 9 + ext;
            end else begin
               f = $urandom_range(1, 6);
               ln = f + 2;
            end
            d = $urandom_range(1, (gen_out > HISTORY_DEPTH) ? HISTORY_DEPTH : gen_out) - 1;
            plan_b.push_back(8'((f << 5) | ((d >> 8) & 8'h1f)));
            if (f == 7) plan_b.push_back(8'(ext));
            plan_b.push_back(8'(d));
            gen_out += ln;
         end else begin
            repeat ($urandom_range(1, 3)) plan_b.push_back(8'($urandom_range(0, 255)));
         end
      end
      // truncate now and then
      if (plan_b.size() > 1 && $urandom_range(0, 9) == 0) void'(plan_b.pop_back());
      for (int i = 0; i < plan_b.size(); i++) begin
         send_item(plan_b[i], i == plan_b.size() - 1);
         foreach (fresh_q[k]) group_q.push_back(fresh_q[k]);
      end
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // receiver: random stall, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left = 0;
      end else if (hold_ask != hold_done) begin
         hold_done = hold_ask;
         hold_left = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
      end
   end

   // check each result mid-cycle; it is taken at the next rising edge
   always @(negedge clock) begin
      group_type got;
      group_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.lanes = {rsp_ch.lane_7, rsp_ch.lane_6, rsp_ch.lane_5, rsp_ch.lane_4,
                      rsp_ch.lane_3, rsp_ch.lane_2, rsp_ch.lane_1, rsp_ch.lane_0};
         got.cnt = rsp_ch.byte_count;
         got.last = rsp_ch.run_last;
         got.err = rsp_ch.error_flag;
         got.total = rsp_ch.total_length;
         if (group_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: lanes %h cnt %0d", got.lanes, got.cnt);
         end else begin
            want = group_q.pop_front();
            if (got.lanes !== want.lanes || got.cnt !== want.cnt ||
                got.last !== want.last || got.err !== want.err ||
                got.total !== want.total) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: want lanes %h cnt %0d last %b err %b total %0d",
                           want.lanes, want.cnt, want.last, want.err, want.total);
                  $display("          got  lanes %h cnt %0d last %b err %b total %0d",
                           got.lanes, got.cnt, got.last, got.err, got.total);
               end
            end
         end
      end
   end

   initial begin
      int target;
      req_ch.valid <= 1'b0;
      req_ch.in_byte <= 8'h00;
      req_ch.block_end <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.data <= '0;
      tx_idle = 0;
      rx_idle = 0;
      mismatches = 0;
      items_sent = 0;
      foreach (ring[i]) ring[i] = 8'h00;
      dec_count = 0;
      dec_phase = PH_CTRL;
      lit_left = 0;
      match_len = 0;
      dist_high = 0;
      dec_err = 1'b0;
      out_limit = LIMIT_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         send_item(dir_tab[i].in_byte, dir_tab[i].block_end);
         // typed rows replace the decoder's answer
         if (dir_tab[i].typed) begin
            if (dir_tab[i].block_end) group_q.push_back(dir_tab[i].want);
         end else begin
            foreach (fresh_q[k]) group_q.push_back(fresh_q[k]);
         end
      end
      idle_drain();

      for (int p = 0; p < 8; p++) begin
         if (p > 0) write_limit(limits[p - 1]);
         tx_idle = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 1) ? 60 : 33) : 0;
         rx_idle = (p % 4 == 2) ? 60 : ((p % 4 == 3) ? 33 : 0);
         if (p == 2) hold_ask++;
         target = items_sent + 48;
         while (items_sent < target) begin
            send_block();
            if (p == 3 && items_sent > target - 30 && items_sent < target - 20) begin
               req_ch.valid <= 1'b0;
               while (group_q.size() != 0) @(posedge clock);
               @(posedge clock);
            end
         end
         idle_drain();
      end

      if (mismatches == 0 && group_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
